### hw/rtl/assert_macros.svh
// Assertion helpers for the scheduler RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### hw/rtl/ptts_pkg.sv
package ptts_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  // period in the upper byte, countdown in the lower byte
  localparam int ENTRY_W       = 16;

  typedef logic [31:0] in_tdata_t;   // slot, period, first_delay, handler_present
  typedef logic [7:0]  out_tdata_t;  // status, task_slot
  typedef logic [2:0]  tslot_t;
  typedef logic [3:0]  cnt_t;        // 0 .. MAX_RESULTS

  typedef enum logic {
    FUNC_CREATE = 1'b0,
    FUNC_TICK   = 1'b1
  } func_t;

  typedef enum logic {
    KIND_CREATE = 1'b0,
    KIND_DUE    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_TAKEN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // result request from the controller to the output register
  typedef struct packed {
    logic    valid;
    kind_t   kind;
    status_t status;
    tslot_t  task_slot;
    logic    last;
  } res_t;

endpackage

### hw/rtl/ptts_ram.sv
// Simple dual-port RAM, one write port, one registered read port.
module ptts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ptts_out.sv
// Output register: takes one request when empty or being drained.
module ptts_out (
  input  logic                   clk,
  input  logic                   rst,
  input  ptts_pkg::res_t         push,
  output logic                   push_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output ptts_pkg::out_tdata_t   m_tdata,   // [1:0] status, [4:2] task_slot
  output logic                   m_tuser,   // kind
  output logic                   m_tlast    // last
);

  ptts_pkg::res_t hold;

  assign push_ready = !hold.valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold.valid <= 1'b0;
    end else if (push.valid && push_ready) begin
      hold <= push;
    end else if (m_tready) begin
      hold.valid <= 1'b0;
    end
  end

  assign m_tvalid = hold.valid;
  assign m_tdata  = ptts_pkg::out_tdata_t'({hold.task_slot, hold.status});
  assign m_tuser  = hold.kind;
  assign m_tlast  = hold.last;

endmodule

### hw/rtl/ptts_ctrl.sv
`include "assert_macros.svh"

// Slot table controller: valid bits in flops, period/countdown in RAM.
// Tick walks one slot per cycle unless a full output register stalls it: read slot i+1 while writing back slot i.
module ptts_ctrl #(
  parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ptts_pkg::func_t  func,
  input  logic [7:0]       slot,
  input  logic [7:0]       period,
  input  logic [7:0]       first_delay,
  input  logic             handler_present,
  output ptts_pkg::res_t   push,
  input  logic             push_ready
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  ptts_pkg::state_t     state, state_next;
  logic [IDX_W-1:0]     ev_idx, ev_idx_next;
  logic                 pend_valid, pend_valid_next;
  logic [IDX_W-1:0]     pend_idx, pend_idx_next;
  ptts_pkg::cnt_t       count, count_next;
  logic [NUM_TASKS-1:0] slot_valid, slot_valid_next;

  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  logic [ptts_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [7:0]       rd_period, rd_cd;
  logic             cur_valid, due, report, stall;
  logic [IDX_W-1:0] slot_idx;
  ptts_pkg::status_t create_status;

  ptts_ram #(
    .WIDTH (ptts_pkg::ENTRY_W),
    .DEPTH (NUM_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_period = ram_rdata[15:8];
  assign rd_cd     = ram_rdata[7:0];
  assign cur_valid = slot_valid[ev_idx];
  assign due       = cur_valid && (rd_cd == 8'd0);
  assign report    = due && (count < ptts_pkg::MAX_RESULTS);
  assign slot_idx  = slot[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptts_pkg::ST_IDLE;
      ev_idx     <= '0;
      pend_valid <= 1'b0;
      count      <= '0;
      slot_valid <= '0;
    end else begin
      state      <= state_next;
      ev_idx     <= ev_idx_next;
      pend_valid <= pend_valid_next;
      count      <= count_next;
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
  end

  always_comb begin
    state_next      = state;
    ev_idx_next     = ev_idx;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    count_next      = count;
    slot_valid_next = slot_valid;
    push            = '0;
    s_tready        = 1'b0;
    stall           = 1'b0;
    create_status   = ptts_pkg::STAT_OK;
    ram_we          = 1'b0;
    ram_waddr       = ev_idx;
    ram_wdata       = {rd_period, rd_cd - 8'd1};
    ram_re          = 1'b0;
    ram_raddr       = ev_idx + 1'b1;

    unique case (state)
      ptts_pkg::ST_IDLE: begin
        s_tready = push_ready;
        if (s_tvalid && push_ready) begin
          if (func == ptts_pkg::FUNC_CREATE) begin
            priority if (slot >= 8'(NUM_TASKS)) begin
              create_status = ptts_pkg::STAT_RANGE;
            end else if (slot_valid[slot_idx]) begin
              create_status = ptts_pkg::STAT_TAKEN;
            end else begin
              create_status             = ptts_pkg::STAT_OK;
              ram_we                    = 1'b1;
              ram_waddr                 = slot_idx;
              ram_wdata                 = {period, first_delay};
              slot_valid_next[slot_idx] = handler_present;
            end
            push.valid     = 1'b1;
            push.kind      = ptts_pkg::KIND_CREATE;
            push.status    = create_status;
            push.task_slot = '0;
            push.last      = 1'b1;
          end else begin
            ram_re          = 1'b1;
            ram_raddr       = '0;
            ev_idx_next     = '0;
            pend_valid_next = 1'b0;
            count_next      = '0;
            state_next      = ptts_pkg::ST_WALK;
          end
        end
      end

      ptts_pkg::ST_WALK: begin
        // a new due slot pushes the held one out; wait if the output is busy
        stall = report && pend_valid && !push_ready;
        if (!stall) begin
          if (cur_valid) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_period, due ? rd_period : (rd_cd - 8'd1)};
          end
          if (report) begin
            count_next      = count + 1'b1;
            pend_valid_next = 1'b1;
            pend_idx_next   = ev_idx;
            if (pend_valid) begin
              push.valid     = 1'b1;
              push.kind      = ptts_pkg::KIND_DUE;
              push.status    = ptts_pkg::STAT_OK;
              push.task_slot = ptts_pkg::tslot_t'(pend_idx);
              push.last      = 1'b0;
            end
          end
          if (ev_idx == LAST_IDX) begin
            state_next = ptts_pkg::ST_FLUSH;
          end else begin
            ram_re      = 1'b1;
            ev_idx_next = ev_idx + 1'b1;
          end
        end
      end

      ptts_pkg::ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ptts_pkg::ST_IDLE;
        end else if (push_ready) begin
          push.valid      = 1'b1;
          push.kind       = ptts_pkg::KIND_DUE;
          push.status     = ptts_pkg::STAT_OK;
          push.task_slot  = ptts_pkg::tslot_t'(pend_idx);
          push.last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ptts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ptts_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_push_taken, clk, rst, push.valid |-> push_ready)
  `ASSERT_CLK(a_count_cap, clk, rst, count <= ptts_pkg::MAX_RESULTS)
  `ASSERT_CLK(a_stall_hold, clk, rst, (state == ptts_pkg::ST_WALK && stall) |=> (state == ptts_pkg::ST_WALK && $stable(ev_idx)))
  `ASSERT_NEVER(a_ram_clash, clk, rst, ram_we && ram_re && (ram_waddr == ram_raddr))

endmodule

### hw/rtl/periodic_task_tick_scheduler_core.sv
// Channel  Dir  Handshake          tuser  tdata (low bit up)                                 tlast
// s_*      in   s_tvalid/s_tready  func   slot[7:0] period[15:8] first_delay[23:16] hp[24]   -
// m_*      out  m_tvalid/m_tready  kind   status[1:0] task_slot[4:2]                         last
//
// Create request: status result loaded into the output register when the request is accepted.
// Tick request: one slot per cycle, unless stalled, through the RAM read-modify-write
//   pipe (read slot i+1 while slot i is written back), then a flush state emits the last held result, if any.
// Reset (rst, synchronous) clears the valid bits at once; period/countdown RAM needs no
//   clearing pass since an entry is only used while its valid bit is set, set only by a write.
// A low m_tready with a full output register holds the walk when another due result needs it.
module periodic_task_tick_scheduler_core #(
  parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  ptts_pkg::in_tdata_t   s_tdata,   // [7:0] slot, [15:8] period,
                                           // [23:16] first_delay, [24] handler_present
  input  logic                  s_tuser,   // func
  // results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output ptts_pkg::out_tdata_t  m_tdata,   // [1:0] status, [4:2] task_slot
  output logic                  m_tuser,   // kind
  output logic                  m_tlast    // last
);

  ptts_pkg::res_t  push;
  logic            push_ready;
  ptts_pkg::func_t func;

  assign func = ptts_pkg::func_t'(s_tuser);

  // slot table and walk sequencer
  ptts_ctrl #(
    .NUM_TASKS (NUM_TASKS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .func            (func),
    .slot            (s_tdata[7:0]),
    .period          (s_tdata[15:8]),
    .first_delay     (s_tdata[23:16]),
    .handler_present (s_tdata[24]),
    .push            (push),
    .push_ready      (push_ready)
  );

  // result register toward the master side
  ptts_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
